// File: rtl/core/lrgla_pkg.sv
// package for the logistic regression gradient accumulator
// holds payload structs, fixed-point constants and the rom content functions
package lrgla_pkg;

    localparam int unsigned WeightBits = 32;
    localparam int unsigned AccBits    = 48;
    localparam int unsigned CfgIdxBits = 3;
    localparam int unsigned InFeatures = 7;
    localparam int unsigned SigBits    = 17;
    localparam int unsigned SpBits     = 21;
    // z edge of the tables, 10.0 in q16.16
    localparam logic signed [AccBits-1:0] EdgeQ16 = 48'sd655360;
    localparam logic [SigBits-1:0] OneQ16 = 17'd65536;
    // reciprocal of five scaled by 2^18
    localparam logic [15:0] RecipFive = 16'd52429;

    localparam logic [CfgIdxBits-1:0] REG_W_BIAS   = 3'd0;
    localparam logic [CfgIdxBits-1:0] REG_W_CLASS  = 3'd1;
    localparam logic [CfgIdxBits-1:0] REG_W_SEX    = 3'd2;
    localparam logic [CfgIdxBits-1:0] REG_W_AGE    = 3'd3;
    localparam logic [CfgIdxBits-1:0] REG_W_GUESTS = 3'd4;
    localparam logic [CfgIdxBits-1:0] REG_W_FAMILY = 3'd5;
    localparam logic [CfgIdxBits-1:0] REG_W_FARE   = 3'd6;

    typedef struct packed {
        logic [1:0]  passenger_class;
        logic        sex_flag;
        logic [6:0]  age_years;
        logic [3:0]  guest_count;
        logic [3:0]  family_count;
        logic [17:0] fare_value;
        logic        label;
        logic        last_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [AccBits-1:0] grad_bias;
        logic signed [AccBits-1:0] grad_class;
        logic signed [AccBits-1:0] grad_sex;
        logic signed [AccBits-1:0] grad_age;
        logic signed [AccBits-1:0] grad_guests;
        logic signed [AccBits-1:0] grad_family;
        logic signed [AccBits-1:0] grad_fare;
        logic signed [AccBits-1:0] log_likelihood;
        logic [15:0]               sample_total;
    } t_out_item;

    localparam logic [63:0] OneQ30 = 64'd1 << 30;

    // unsigned restoring division, used only while building the roms
    function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (OneQ30 >> 1)) >> 30;
    endfunction

    // e^-f for f in [0,1], q.30
    function automatic logic [63:0] exp_series(input logic [63:0] f);
        logic signed [63:0] sum;
        logic [63:0]        term;
        sum  = OneQ30;
        term = OneQ30;
        for (int i = 1; i < 64; i++) begin
            if (term != 64'd0) begin
                term = udiv(q30_mul(term, f), 64'(i));
                if (i[0]) sum = sum - term;
                else      sum = sum + term;
            end
        end
        return (sum > 0) ? sum : 64'd0;
    endfunction

    function automatic logic [63:0] exp_neg_q30(input logic [63:0] a);
        logic [63:0] e;
        logic [63:0] e1;
        logic [63:0] n;
        e  = exp_series(a & (OneQ30 - 64'd1));
        e1 = exp_series(OneQ30);
        n  = a >> 30;
        for (int i = 0; i < 64; i++) begin
            if (i < n) e = q30_mul(e, e1);
        end
        return e;
    endfunction

    function automatic logic [63:0] log1p_q30(input logic [63:0] u);
        logic [63:0] den;
        logic [63:0] s;
        logic [63:0] s2;
        logic [63:0] p;
        logic [63:0] sum;
        den = 2 * OneQ30 + u;
        s   = udiv((u << 30) + (den >> 1), den);
        s2  = q30_mul(s, s);
        p   = s;
        sum = 64'd0;
        for (int k = 1; k < 200; k += 2) begin
            if (p != 64'd0) begin
                sum = sum + udiv(p, 64'(k));
                p   = q30_mul(p, s2);
            end
        end
        return 2 * sum;
    endfunction

    // sel 0 gives sigmoid, sel 1 gives softplus, both q16.16 at the bin centre
    function automatic logic [31:0] rom_value(input int k, input int depth, input bit sel);
        logic [63:0] odd;
        logic [63:0] offs;
        logic [63:0] a;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] l;
        logic [63:0] d64;
        logic        nonneg;
        d64    = 64'(depth);
        odd    = 64'(2 * k + 1);
        nonneg = (odd >= d64);
        offs   = nonneg ? odd - d64 : d64 - odd;
        a      = udiv(64'd10 * OneQ30 * offs + (d64 >> 1), d64);
        e      = exp_neg_q30(a);
        den    = OneQ30 + e;
        l      = log1p_q30(e);
        if (sel == 1'b0) begin
            if (nonneg) return 32'(udiv((64'd1 << 46) + (den >> 1), den));
            else        return 32'(udiv((e << 16) + (den >> 1), den));
        end else begin
            if (nonneg) return 32'((a + l + (64'd1 << 13)) >> 14);
            else        return 32'((l + (64'd1 << 13)) >> 14);
        end
    endfunction

endpackage

// File: rtl/core/logreg_gradient_loglik_accumulator_unit.sv
// top level of the logistic regression gradient and log-likelihood accumulator
// depends on lrgla_pkg for payload structs, constants and rom contents

// After acceptance a sample passes S_ZMAC, S_IDX1, S_IDX2, S_ROM, S_CSET,
// S_GMAC and S_CNT in that order before the block is ready again:
// a single 33x20 signed multiplier is shared, first for the FEATURE_COUNT weight
// products that form z, then for the FEATURE_COUNT gradient products. Between the
// two passes, S_IDX1 and S_IDX2 turn z into a table index, S_ROM does the
// registered rom read and S_CSET forms the error term. The sample that ends a
// batch also passes S_FIN to load the output register; the result then sits
// there while the next sample is already accepted, and the block waits longer
// only when a second batch ends before the first result is taken.
module logreg_gradient_loglik_accumulator_unit #(
    parameter int FEATURE_COUNT = 7,
    parameter int TABLE_DEPTH   = 1024,
    parameter int COUNT_BITS    = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  lrgla_pkg::t_in_item           i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output lrgla_pkg::t_out_item          o_out_data,
    input  logic                          i_cfg_we,
    input  logic [lrgla_pkg::CfgIdxBits-1:0] i_cfg_idx,
    input  logic [lrgla_pkg::WeightBits-1:0] i_cfg_wdata
);
    import lrgla_pkg::*;

    localparam int FB = $clog2(FEATURE_COUNT);
    localparam int IB = $clog2(TABLE_DEPTH);
    localparam logic [FB-1:0] LastFeat = FB'(FEATURE_COUNT - 1);
    localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ZMAC  = 9'b000000010,
        S_IDX1  = 9'b000000100,
        S_IDX2  = 9'b000001000,
        S_ROM   = 9'b000010000,
        S_CSET  = 9'b000100000,
        S_GMAC  = 9'b001000000,
        S_CNT   = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic signed [WeightBits-1:0] r_w [FEATURE_COUNT];
    logic signed [AccBits-1:0]    r_grad [FEATURE_COUNT];
    logic signed [AccBits-1:0]    r_ll;
    logic [COUNT_BITS-1:0]        r_cnt;
    t_in_item                     r_item;
    logic [FB-1:0]                r_i;
    logic signed [AccBits-1:0]    r_z;
    logic                         r_lo, r_hi;
    logic [14:0]                  r_q;
    logic [IB-1:0]                r_idx;
    logic [SigBits-1:0]           r_sig;
    logic [SpBits-1:0]            r_sp;
    logic signed [SigBits:0]      r_c;
    logic                         r_out_valid;
    t_out_item                    r_out;

    // rom built at elaboration, read through a register
    logic [SigBits-1:0] w_sig_rom [TABLE_DEPTH];
    logic [SpBits-1:0]  w_sp_rom  [TABLE_DEPTH];
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_rom
        localparam logic [31:0] SigV = rom_value(g, TABLE_DEPTH, 1'b0);
        localparam logic [31:0] SpV  = rom_value(g, TABLE_DEPTH, 1'b1);
        assign w_sig_rom[g] = SigV[SigBits-1:0];
        assign w_sp_rom[g]  = SpV[SpBits-1:0];
    end

    // feature of the current step, q.8
    logic [19:0] w_feat;
    always_comb begin
        case (r_i)
            FB'(0):  w_feat = 20'd256;
            FB'(1):  w_feat = {10'd0, r_item.passenger_class, 8'd0};
            FB'(2):  w_feat = {11'd0, r_item.sex_flag, 8'd0};
            FB'(3):  w_feat = {5'd0, r_item.age_years, 8'd0};
            FB'(4):  w_feat = {8'd0, r_item.guest_count, 8'd0};
            FB'(5):  w_feat = {8'd0, r_item.family_count, 8'd0};
            FB'(6):  w_feat = {2'd0, r_item.fare_value};
            default: w_feat = 20'd0;
        endcase
    end

    // shared multiplier
    logic signed [32:0] w_mul_a;
    logic signed [52:0] w_prod;
    logic signed [52:0] w_prod_sh;
    logic signed [AccBits-1:0] w_term;
    assign w_mul_a   = (r_state == S_GMAC) ? 33'(r_c) : 33'(r_w[r_i]);
    assign w_prod    = w_mul_a * $signed({1'b0, w_feat});
    assign w_prod_sh = w_prod >>> 8;
    assign w_term    = w_prod_sh[AccBits-1:0];

    function automatic logic signed [AccBits-1:0] sat_add(
        input logic signed [AccBits-1:0] a, input logic signed [AccBits-1:0] b);
        logic signed [AccBits:0] s;
        s = {a[AccBits-1], a} + {b[AccBits-1], b};
        if (s[AccBits] != s[AccBits-1])
            return s[AccBits] ? {1'b1, {(AccBits-1){1'b0}}} : {1'b0, {(AccBits-1){1'b1}}};
        return s[AccBits-1:0];
    endfunction

    // table index: floor((z+10) * depth / 20), done as shift by 18 then divide by five
    logic [AccBits-1:0] w_u;
    logic [20:0]        w_u21;
    logic [20+IB+1:0]   w_ud;
    logic [31:0]        w_q5;
    logic [31:0]        w_idx_raw;
    assign w_u       = r_z + EdgeQ16;
    assign w_u21     = w_u[20:0];
    assign w_ud      = (20+IB+2)'(w_u21) * (20+IB+2)'(TABLE_DEPTH);
    assign w_q5      = 32'(r_q) * 32'(RecipFive);
    assign w_idx_raw = w_q5 >> 18;

    // log-likelihood term
    logic signed [AccBits-1:0] w_ll_term;
    always_comb begin
        if (r_lo)      w_ll_term = r_item.label ? r_z : '0;
        else if (r_hi) w_ll_term = r_item.label ? '0 : -r_z;
        else           w_ll_term = (r_item.label ? r_z : '0) - AccBits'(r_sp);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_ZMAC;
            S_ZMAC: if (r_i == LastFeat) n_state = S_IDX1;
            S_IDX1: n_state = S_IDX2;
            S_IDX2: n_state = S_ROM;
            S_ROM:  n_state = S_CSET;
            S_CSET: n_state = S_GMAC;
            S_GMAC: if (r_i == LastFeat) n_state = S_CNT;
            S_CNT:  n_state = r_item.last_sample ? S_FIN : S_IDLE;
            S_FIN:  if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_cnt       <= '0;
            r_ll        <= '0;
            for (int k = 0; k < FEATURE_COUNT; k++) begin
                r_w[k]    <= '0;
                r_grad[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN && (!r_out_valid || i_out_ready)) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready)                   r_out_valid <= 1'b0;
            if (i_cfg_we && (32'(i_cfg_idx) < 32'(FEATURE_COUNT))
                    && (i_cfg_idx <= REG_W_FARE))
                r_w[FB'(i_cfg_idx)] <= i_cfg_wdata;
            unique case (r_state)
                S_IDLE: begin
                    r_i <= '0;
                    r_z <= '0;
                    if (i_in_valid) r_item <= i_in_data;
                end
                S_ZMAC: begin
                    r_z <= r_z + w_term;
                    r_i <= (r_i == LastFeat) ? '0 : r_i + FB'(1);
                end
                S_IDX1: begin
                    r_lo <= (r_z < -EdgeQ16);
                    r_hi <= (r_z >= EdgeQ16);
                    r_q  <= 15'(w_ud >> 18);
                end
                S_IDX2: begin
                    if (w_idx_raw >= 32'(TABLE_DEPTH)) r_idx <= IB'(TABLE_DEPTH - 1);
                    else                               r_idx <= w_idx_raw[IB-1:0];
                end
                S_ROM: begin
                    r_sig <= w_sig_rom[r_idx];
                    r_sp  <= w_sp_rom[r_idx];
                end
                S_CSET: begin
                    if (r_lo)      r_c <= {1'b0, r_item.label, 16'd0};
                    else if (r_hi) r_c <= $signed({1'b0, r_item.label, 16'd0})
                                          - $signed({1'b0, OneQ16});
                    else           r_c <= $signed({1'b0, r_item.label, 16'd0})
                                          - $signed({1'b0, r_sig});
                    r_ll <= sat_add(r_ll, w_ll_term);
                end
                S_GMAC: begin
                    r_grad[r_i] <= sat_add(r_grad[r_i], w_term);
                    r_i <= (r_i == LastFeat) ? '0 : r_i + FB'(1);
                end
                S_CNT: begin
                    if (r_cnt != CountMax) r_cnt <= r_cnt + COUNT_BITS'(1);
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_ll        <= '0;
                        r_cnt       <= '0;
                        for (int k = 0; k < FEATURE_COUNT; k++) r_grad[k] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // output snapshot, payload only
    logic signed [AccBits-1:0] w_g [InFeatures];
    logic [15:0] w_total;
    always_comb begin
        for (int k = 0; k < InFeatures; k++) begin
            if (k < FEATURE_COUNT) w_g[k] = r_grad[k];
            else                   w_g[k] = '0;
        end
        if (32'(r_cnt) > 32'd65535) w_total = 16'hFFFF;
        else                        w_total = 16'(r_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && (!r_out_valid || i_out_ready)) begin
            r_out.grad_bias      <= w_g[0];
            r_out.grad_class     <= w_g[1];
            r_out.grad_sex       <= w_g[2];
            r_out.grad_age       <= w_g[3];
            r_out.grad_guests    <= w_g[4];
            r_out.grad_family    <= w_g[5];
            r_out.grad_fare      <= w_g[6];
            r_out.log_likelihood <= r_ll;
            r_out.sample_total   <= w_total;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/core/lrgla_checker.sv
// port-level checks for the gradient accumulator
// depends on lrgla_pkg and binds to logreg_gradient_loglik_accumulator_unit
module lrgla_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input lrgla_pkg::t_out_item o_out_data
);
    import lrgla_pkg::*;

    // a result that waits keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // one sample at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after a transaction");

    // a result appears only at the end of a sample's work
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared without sample work");

    // every batch holds at least its last sample
    a_total_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.sample_total != 16'd0)
        else $error("empty batch count");

endmodule

bind logreg_gradient_loglik_accumulator_unit lrgla_checker u_lrgla_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
